// ----- hw/rtl/ppe_pkg.sv -----
// shared constants and types for the particle pool engine
package ppe_pkg;

    localparam int POOL_SIZE = 32;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int MARK_W    = $clog2(POOL_SIZE + 1);
    localparam int Q_W       = 24;
    localparam int EXT_W     = 16;
    localparam int HUE_W     = 2;
    localparam int DT_W      = 16;
    localparam int ALPHA_W   = 9;
    localparam int FADE_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int KIND_W    = 2;

    localparam logic [FADE_W-1:0]  FADE_RESET  = 8'd4;
    localparam logic [ALPHA_W-1:0] ALPHA_START = 9'd255;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_DROP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIVE     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // per-slot record held in memory
    localparam int REC_W = 4 * Q_W + Q_W + EXT_W + Q_W + HUE_W + ALPHA_W;

    typedef struct packed {
        logic signed [Q_W-1:0]   px;
        logic signed [Q_W-1:0]   py;
        logic signed [Q_W-1:0]   vx;
        logic signed [Q_W-1:0]   vy;
        logic signed [Q_W-1:0]   ang;
        logic signed [Q_W-1:0]   spin;
        logic [EXT_W-1:0]        ext;
        logic [HUE_W-1:0]        hue;
        logic [ALPHA_W-1:0]      alpha;
    } part_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_WR,
        ST_TK_RD,
        ST_TK_WAIT,
        ST_TK_X,
        ST_TK_Y,
        ST_TK_A,
        ST_TK_WR,
        ST_EMIT,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_A
    } step_sel_t;

    typedef struct packed {
        logic                 start;
        logic signed [Q_W-1:0] base;
        logic signed [Q_W-1:0] rate;
    } step_req_t;

endpackage

// ----- hw/rtl/ppe_if.sv -----
// valid/ready channel interfaces for the particle pool engine
interface ppe_in_if;
    import ppe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic signed [Q_W-1:0] start_x;
    logic signed [Q_W-1:0] start_y;
    logic signed [Q_W-1:0] velocity_x;
    logic signed [Q_W-1:0] velocity_y;
    logic [EXT_W-1:0]      extent;
    logic signed [Q_W-1:0] spin_rate;
    logic [HUE_W-1:0]      hue;
    logic [DT_W-1:0]       frame_time;
    modport source (output valid, action, start_x, start_y, velocity_x, velocity_y,
                    extent, spin_rate, hue, frame_time, input ready);
    modport sink (input valid, action, start_x, start_y, velocity_x, velocity_y,
                  extent, spin_rate, hue, frame_time, output ready);
endinterface

interface ppe_out_if;
    import ppe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     record_kind;
    logic [SLOT_W-1:0]     slot;
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic [EXT_W-1:0]      side;
    logic signed [Q_W-1:0] angle;
    logic [HUE_W-1:0]      shade;
    logic [7:0]            opacity;
    logic                  last;
    modport source (output valid, record_kind, slot, pos_x, pos_y, side, angle, shade,
                    opacity, last, input ready);
    modport sink (input valid, record_kind, slot, pos_x, pos_y, side, angle, shade,
                  opacity, last, output ready);
endinterface

// ----- hw/rtl/ppe_ram.sv -----
// generic ram with one write port, one read port and registered read
module ppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/ppe_step.sv -----
// shared multiply, floor shift and saturating add unit; the product and base are registered
module ppe_step
    import ppe_pkg::*;
(
    input  logic                  clk,
    input  step_req_t             req,
    input  logic [DT_W-1:0]       dt,
    output logic signed [Q_W-1:0] result
);
    logic signed [Q_W+DT_W:0]   prod_reg;
    logic signed [Q_W+DT_W:0]   prod_next;
    logic signed [Q_W-1:0]      base_reg;
    logic signed [Q_W:0]        q;
    logic signed [Q_W+1:0]      sum;

    assign prod_next = req.rate * $signed({1'b0, dt});

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
            base_reg <= req.base;
        end
    end

    // arithmetic shift floors toward minus infinity
    assign q   = prod_reg[Q_W+DT_W:DT_W];
    assign sum = {{2{base_reg[Q_W-1]}}, base_reg} + {q[Q_W], q};

    always_comb
    begin
        if (sum > $signed({3'b000, {(Q_W-1){1'b1}}}))
        begin
            result = {1'b0, {(Q_W-1){1'b1}}};
        end
        else if (sum < $signed({3'b111, {(Q_W-1){1'b0}}}))
        begin
            result = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            result = sum[Q_W-1:0];
        end
    end
endmodule

// ----- hw/rtl/particle_pool_engine_unit.sv -----
// particle pool engine top level: sequencer, slot memory and shared step unit
// One item at a time. An add scans the live flags one slot a cycle up to the
// high-water mark, then writes the first free slot or reports a drop if the
// pool is full. A tick walks every slot below the mark, using one shared
// multiplier three times per live slot; a surviving slot gives a live record,
// one that fades out this tick gives none; the end record closes the tick.
// Results leave through an output register; the block takes no input until
// the last result of an item is in that register. No clearing pass is needed.
module particle_pool_engine_unit
    import ppe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [FADE_W-1:0] cfg_wdata,
    ppe_in_if.sink            in_ch,
    ppe_out_if.source         out_ch
);
    state_t state_reg, state_next;
    logic [FADE_W-1:0] fade_reg;
    logic [POOL_SIZE-1:0] live_reg, live_next;
    logic [MARK_W-1:0] mark_reg, mark_next;
    logic [MARK_W-1:0] idx_reg, idx_next;
    logic act_reg;
    logic [DT_W-1:0] dt_reg;
    part_t new_reg;
    part_t cur_reg, cur_next;
    logic [ALPHA_W-1:0] alpha_dec;

    logic we;
    part_t wdata, rdata;
    logic signed [Q_W-1:0] step_res;
    step_req_t sreq;

    logic ov_reg, ov_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    part_t opart_reg, opart_next;

    logic [IDX_W-1:0] idx_lo;
    assign idx_lo = idx_reg[IDX_W-1:0];

    ppe_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(idx_lo),
        .wdata(wdata),
        .raddr(idx_lo),
        .rdata(rdata)
    );

    ppe_step u_step (
        .clk   (clk),
        .req   (sreq),
        .dt    (dt_reg),
        .result(step_res)
    );

    assign alpha_dec = cur_reg.alpha - {1'b0, fade_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fade_reg  <= FADE_RESET;
            live_reg  <= '0;
            mark_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            mark_reg  <= mark_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                fade_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        kind_reg  <= kind_next;
        oslot_reg <= oslot_next;
        opart_reg <= opart_next;
        if (in_ch.valid && in_ch.ready)
        begin
            act_reg       <= in_ch.action;
            dt_reg        <= in_ch.frame_time;
            new_reg.px    <= in_ch.start_x;
            new_reg.py    <= in_ch.start_y;
            new_reg.vx    <= in_ch.velocity_x;
            new_reg.vy    <= in_ch.velocity_y;
            new_reg.ext   <= in_ch.extent;
            new_reg.spin  <= in_ch.spin_rate;
            new_reg.hue   <= in_ch.hue;
            new_reg.ang   <= '0;
            new_reg.alpha <= ALPHA_START;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (in_ch.action == ACT_TICK) ? ST_TK_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < mark_reg && live_reg[idx_lo])
                begin
                    state_next = ST_SCAN;
                end
                else if (idx_reg < MARK_W'(POOL_SIZE))
                begin
                    state_next = ST_ADD_WR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ADD_WR:  state_next = ST_EMIT;
            ST_TK_RD:
            begin
                if (idx_reg >= mark_reg)
                begin
                    state_next = ST_END;
                end
                else if (live_reg[idx_lo])
                begin
                    state_next = ST_TK_WAIT;
                end
            end
            ST_TK_WAIT: state_next = ST_TK_X;
            ST_TK_X:    state_next = ST_TK_Y;
            ST_TK_Y:    state_next = ST_TK_A;
            ST_TK_A:    state_next = ST_TK_WR;
            ST_TK_WR:
            begin
                if (alpha_dec[ALPHA_W-1])
                begin
                    state_next = ST_TK_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    state_next = (act_reg == ACT_TICK) ? ST_TK_RD : ST_IDLE;
                end
            end
            ST_END:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        live_next   = live_reg;
        mark_next   = mark_reg;
        we          = 1'b0;
        wdata       = cur_reg;
        sreq.start  = 1'b0;
        sreq.base   = cur_reg.px;
        sreq.rate   = cur_reg.vx;
        ov_next     = ov_reg && !out_ch.ready;
        kind_next   = kind_reg;
        oslot_next  = oslot_reg;
        opart_next  = opart_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
            end
            ST_SCAN:
            begin
                if (idx_reg < mark_reg && live_reg[idx_lo])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (idx_reg >= MARK_W'(POOL_SIZE))
                begin
                    // pool full
                    kind_next  = KIND_ADD_DROP;
                    oslot_next = '0;
                    opart_next = '0;
                end
            end
            ST_ADD_WR:
            begin
                we                 = 1'b1;
                wdata              = new_reg;
                live_next[idx_lo]  = 1'b1;
                if (idx_reg == mark_reg)
                begin
                    mark_next = mark_reg + 1'b1;
                end
                kind_next  = KIND_ADD_OK;
                oslot_next = SLOT_W'(idx_reg);
                opart_next = new_reg;
            end
            ST_TK_RD:
            begin
                if (idx_reg < mark_reg && !live_reg[idx_lo])
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TK_WAIT:
            begin
                cur_next   = rdata;
                sreq.start = 1'b1;
                sreq.base  = rdata.px;
                sreq.rate  = rdata.vx;
            end
            ST_TK_X:
            begin
                sreq.start = 1'b1;
                sreq.base  = cur_reg.py;
                sreq.rate  = cur_reg.vy;
                cur_next.px = step_res;
            end
            ST_TK_Y:
            begin
                sreq.start = 1'b1;
                sreq.base  = cur_reg.ang;
                sreq.rate  = cur_reg.spin;
                cur_next.py = step_res;
            end
            ST_TK_A:
            begin
                cur_next.ang = step_res;
            end
            ST_TK_WR:
            begin
                we          = 1'b1;
                wdata       = cur_reg;
                wdata.alpha = alpha_dec;
                if (alpha_dec[ALPHA_W-1])
                begin
                    live_next[idx_lo] = 1'b0;
                    idx_next          = idx_reg + 1'b1;
                end
                kind_next        = KIND_LIVE;
                oslot_next       = SLOT_W'(idx_reg);
                opart_next       = cur_reg;
                opart_next.alpha = alpha_dec;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    if (act_reg == ACT_TICK)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_END:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_END;
                    oslot_next = '0;
                    opart_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register beat
    logic [KIND_W-1:0]  okind_reg;
    logic [SLOT_W-1:0]  ooslot_reg;
    part_t              oo_reg;

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EMIT || state_reg == ST_END) && (!ov_reg || out_ch.ready))
        begin
            okind_reg  <= kind_next;
            ooslot_reg <= oslot_next;
            oo_reg     <= opart_next;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.record_kind = okind_reg;
    assign out_ch.slot        = ooslot_reg;
    assign out_ch.pos_x       = oo_reg.px;
    assign out_ch.pos_y       = oo_reg.py;
    assign out_ch.side        = oo_reg.ext;
    assign out_ch.angle       = oo_reg.ang;
    assign out_ch.shade       = oo_reg.hue;
    assign out_ch.opacity     = oo_reg.alpha[7:0];
    assign out_ch.last        = (okind_reg != KIND_LIVE);
endmodule

// ----- bench/ppe_tb_if.sv -----
// the bench drives and watches the channel interfaces declared beside the rtl

// ----- bench/ppe_checker.sv -----
// particle pool predictor and record checker
module ppe_checker
    import ppe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [FADE_W-1:0] cfg_wdata,
    ppe_in_if                 in_ch,
    ppe_out_if                out_ch,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic signed [Q_W-1:0] px;
        logic signed [Q_W-1:0] py;
        logic [EXT_W-1:0]      side;
        logic signed [Q_W-1:0] ang;
        logic [HUE_W-1:0]      shade;
        logic [7:0]            opacity;
        logic                  last;
    } record_t;

    record_t                due_records[$];
    logic [FADE_W-1:0]      fade;
    logic                   alive[POOL_SIZE];
    part_t                  pool[POOL_SIZE];
    int                     mark;

    assign pending = due_records.size();

    function automatic logic signed [Q_W-1:0] euler_step(logic signed [Q_W-1:0] base,
            logic signed [Q_W-1:0] rate, logic [DT_W-1:0] dt);
        longint p;
        longint s;
        p = longint'(rate) * longint'({1'b0, dt});
        s = longint'(base) + (p >>> 16);
        if (s > 8388607)
            s = 8388607;
        if (s < -8388608)
            s = -8388608;
        return s[Q_W-1:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic predict_beat();
        int     slot;
        int     alpha;
        record_t r;
        if (in_ch.action == ACT_ADD)
        begin
            slot = -1;
            for (int i = 0; i < mark; i++)
                if (!alive[i] && slot < 0)
                    slot = i;
            if (slot < 0 && mark < POOL_SIZE)
            begin
                slot = mark;
                mark++;
            end
            r = '0;
            r.last = 1'b1;
            if (slot < 0)
                r.kind = KIND_ADD_DROP;
            else
            begin
                alive[slot]      = 1'b1;
                pool[slot].px    = in_ch.start_x;
                pool[slot].py    = in_ch.start_y;
                pool[slot].vx    = in_ch.velocity_x;
                pool[slot].vy    = in_ch.velocity_y;
                pool[slot].ext   = in_ch.extent;
                pool[slot].spin  = in_ch.spin_rate;
                pool[slot].hue   = in_ch.hue;
                pool[slot].ang   = '0;
                pool[slot].alpha = ALPHA_START;
                r.kind    = KIND_ADD_OK;
                r.slot    = slot[SLOT_W-1:0];
                r.px      = in_ch.start_x;
                r.py      = in_ch.start_y;
                r.side    = in_ch.extent;
                r.shade   = in_ch.hue;
                r.opacity = 8'd255;
            end
            due_records.push_back(r);
        end
        else
        begin
            for (int i = 0; i < mark; i++)
            begin
                if (!alive[i])
                    continue;
                pool[i].px  = euler_step(pool[i].px, pool[i].vx, in_ch.frame_time);
                pool[i].py  = euler_step(pool[i].py, pool[i].vy, in_ch.frame_time);
                pool[i].ang = euler_step(pool[i].ang, pool[i].spin, in_ch.frame_time);
                alpha = int'(pool[i].alpha) - int'(fade);
                pool[i].alpha = alpha[ALPHA_W-1:0];
                if (alpha < 0)
                begin
                    alive[i] = 1'b0;
                    continue;
                end
                r.kind    = KIND_LIVE;
                r.slot    = i[SLOT_W-1:0];
                r.px      = pool[i].px;
                r.py      = pool[i].py;
                r.side    = pool[i].ext;
                r.ang     = pool[i].ang;
                r.shade   = pool[i].hue;
                r.opacity = alpha[7:0];
                r.last    = 1'b0;
                due_records.push_back(r);
            end
            r = '0;
            r.kind = KIND_END;
            r.last = 1'b1;
            due_records.push_back(r);
        end
    endtask

    task automatic compare_beat();
        record_t w;
        if (due_records.size() == 0)
        begin
            report("unexpected record", out_ch.record_kind, 0);
            return;
        end
        w = due_records.pop_front();
        if (out_ch.record_kind !== w.kind) report("record_kind", out_ch.record_kind, w.kind);
        if (out_ch.slot !== w.slot)        report("slot", out_ch.slot, w.slot);
        if (out_ch.pos_x !== w.px)         report("pos_x", out_ch.pos_x, w.px);
        if (out_ch.pos_y !== w.py)         report("pos_y", out_ch.pos_y, w.py);
        if (out_ch.side !== w.side)        report("side", out_ch.side, w.side);
        if (out_ch.angle !== w.ang)        report("angle", out_ch.angle, w.ang);
        if (out_ch.shade !== w.shade)      report("shade", out_ch.shade, w.shade);
        if (out_ch.opacity !== w.opacity)  report("opacity", out_ch.opacity, w.opacity);
        if (out_ch.last !== w.last)        report("last", out_ch.last, w.last);
    endtask

    initial
    begin
        fail_count = 0;
        fade = FADE_RESET;
        mark = 0;
        foreach (alive[i])
            alive[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                fade <= cfg_wdata;
            if (out_ch.valid && out_ch.ready)
                compare_beat();
            if (in_ch.valid && in_ch.ready)
                predict_beat();
        end
    end
endmodule

// ----- bench/tb_top.sv -----
// stimulus and verdict for the particle pool engine
module tb_top;
    import ppe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [FADE_W-1:0] cfg_wdata = '0;
    int                fail_count;
    int                pending;
    int                send_idle = 0;
    int                sink_stall = 0;
    int                hold_cycles = 0;
    longint            cycle_count = 0;

    ppe_in_if  in_ch();
    ppe_out_if out_ch();

    particle_pool_engine_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    ppe_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall);
    end

    function automatic logic signed [Q_W-1:0] rand_q(int mode);
        case (mode)
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return $signed(24'($urandom_range(4095))) - 24'sd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    // valid stays up after a beat until the next call offers or idles
    task automatic send_beat(logic act, logic signed [Q_W-1:0] sx, logic signed [Q_W-1:0] sy,
            logic signed [Q_W-1:0] vx, logic signed [Q_W-1:0] vy, logic [EXT_W-1:0] ext,
            logic signed [Q_W-1:0] spin, logic [HUE_W-1:0] h, logic [DT_W-1:0] dt);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.start_x    <= sx;
        in_ch.start_y    <= sy;
        in_ch.velocity_x <= vx;
        in_ch.velocity_y <= vy;
        in_ch.extent     <= ext;
        in_ch.spin_rate  <= spin;
        in_ch.hue        <= h;
        in_ch.frame_time <= dt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic stop_offering();
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_add();
        send_beat(ACT_ADD, rand_q($urandom_range(3)), rand_q($urandom_range(3)),
                  rand_q($urandom_range(3)), rand_q($urandom_range(3)),
                  16'($urandom), rand_q($urandom_range(3)), 2'($urandom), 16'($urandom));
    endtask

    task automatic send_tick(logic [DT_W-1:0] dt);
        send_beat(ACT_TICK, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), 24'($urandom), 2'($urandom), dt);
    endtask

    task automatic write_fade(logic [FADE_W-1:0] v);
        stop_offering();
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [FADE_W-1:0] fades[5];
        fades = '{8'd0, 8'd255, 8'd64, 8'd1, 8'd17};
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ADD;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        in_ch.velocity_x = '0;
        in_ch.velocity_y = '0;
        in_ch.extent = '0;
        in_ch.spin_rate = '0;
        in_ch.hue = '0;
        in_ch.frame_time = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, saturation both ways, default fade
        send_beat(ACT_ADD, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000,
                  16'hffff, 24'sh7fffff, 2'd3, 16'd0);
        send_beat(ACT_ADD, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
                  16'h0000, 24'sh800000, 2'd0, 16'hffff);
        send_beat(ACT_ADD, 24'sd0, 24'sd0, -24'sd1, 24'sd1, 16'h1234, -24'sd3, 2'd1, 16'd0);
        send_tick(16'hffff);
        send_tick(16'h0000);
        send_tick(16'h0001);
        write_fade(8'd255);
        send_tick(16'h8000);
        send_tick(16'h8000);
        // end record only, then refill freed slots and run the pool full
        send_tick(16'h0100);
        for (int i = 0; i < 34; i++)
            send_add();
        send_tick(16'hffff);

        // random phases across fade settings and idling patterns
        for (int ph = 0; ph < 5; ph++)
        begin
            write_fade(fades[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  sink_stall = 0;  end
                1: begin send_idle = 56; sink_stall = 0;  end
                2: begin send_idle = 0;  sink_stall = 56; end
                default: begin send_idle = 30; sink_stall = 30; end
            endcase
            if (ph == 1)
                hold_cycles = 400;
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(99) < 70)
                    send_add();
                else
                    send_tick(16'($urandom_range(3)) == 0 ? 16'($urandom) :
                              16'($urandom_range(1024)));
            end
        end
        send_idle = 0;
        sink_stall = 0;
        stop_offering();

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
